// ----- src/pair_id_assigner_core_macros.svh -----
// Assertion macros for the pair id assigner.
// Included by pair_id_assigner_core.sv; no other dependencies.
`ifndef PAIR_ID_ASSIGNER_CORE_MACROS_SVH
`define PAIR_ID_ASSIGNER_CORE_MACROS_SVH

// Property that must hold on every clock outside reset.
`define PIA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition that must hold in the clock after the trigger.
`define PIA_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pia_pkg.sv -----
// Shared types and constants for the pair id assigner.
// No dependencies.
`default_nettype none

package pia_pkg;

  localparam int unsigned MAX_PAIRS_DEF = 256;
  localparam int unsigned NODE_BITS_DEF = 16;
  localparam int unsigned NODE_W        = 16;
  localparam int unsigned LINK_ID_W     = 9;

  localparam logic FUNC_ASSIGN = 1'b0;
  localparam logic FUNC_PEEK   = 1'b1;

  typedef struct packed {
    logic              func;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } in_t;

  typedef struct packed {
    logic [LINK_ID_W-1:0] link_id;
    logic                 found;
    logic                 table_full;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/pia_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pia_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/pia_ctrl.sv -----
// Sequencer for the pair id assigner: accept, scan, resolve.
// Depends on pia_pkg.
`default_nettype none

module pia_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          out_stall_i,
  input  wire pia_pkg::sts_t sts_i,
  output pia_pkg::cmd_t      cmd_o
);

  pia_pkg::state_e state_q, state_d;
  logic            out_free;

  assign out_free = !sts_i.out_busy || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pia_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pia_pkg::ST_SCAN;
      end
      pia_pkg::ST_SCAN: begin
        if (sts_i.hit || sts_i.miss) state_d = pia_pkg::ST_RESOLVE;
      end
      pia_pkg::ST_RESOLVE: begin
        if (out_free) state_d = pia_pkg::ST_IDLE;
      end
      default: state_d = pia_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      pia_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      pia_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      pia_pkg::ST_RESOLVE: begin
        cmd_o.emit = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pia_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/pia_dp.sv -----
// Datapath of the pair id assigner: key, scan pointer, pair memory,
// pair count and result register. Depends on pia_pkg and pia_ram.
`default_nettype none

module pia_dp #(
  parameter int unsigned MAX_PAIRS = pia_pkg::MAX_PAIRS_DEF,
  parameter int unsigned NODE_BITS = pia_pkg::NODE_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pia_pkg::in_t  in_data_i,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output pia_pkg::out_t      out_data_o,
  input  wire pia_pkg::cmd_t cmd_i,
  output pia_pkg::sts_t      sts_o
);

  localparam int unsigned KW = 2 * NODE_BITS;
  localparam int unsigned AW = $clog2(MAX_PAIRS);
  localparam int unsigned CW = $clog2(MAX_PAIRS + 1);

  logic [KW-1:0] key_q, key_d;
  logic          func_q;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] cmp_idx_q;
  logic          cmp_vld_q, cmp_vld_d;
  logic [CW-1:0] count_q, count_d;
  logic          hit_q;
  logic [CW-1:0] slot_q;
  logic          out_valid_q, out_valid_d;
  pia_pkg::out_t out_q, out_d;

  logic [31:0]   from_ext, to_ext, id_ext;
  logic [KW-1:0] rdata;
  logic          issue, hit, miss, at_max, insert;

  assign from_ext = 32'(in_data_i.from_node);
  assign to_ext   = 32'(in_data_i.to_node);
  assign key_d    = {from_ext[NODE_BITS-1:0], to_ext[NODE_BITS-1:0]};

  assign issue  = cmd_i.scan && (rd_idx_q < count_q);
  assign hit    = cmd_i.scan && cmp_vld_q && (rdata == key_q);
  assign miss   = cmd_i.scan && !cmp_vld_q && !issue;
  assign at_max = (count_q == CW'(MAX_PAIRS));
  assign insert = cmd_i.emit && !hit_q && (func_q == pia_pkg::FUNC_ASSIGN) && !at_max;

  pia_ram #(
    .WIDTH (KW),
    .DEPTH (MAX_PAIRS)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (insert),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (key_q),
    .re_i    (issue),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    rd_idx_d  = rd_idx_q;
    cmp_vld_d = cmp_vld_q;
    if (cmd_i.load) begin
      rd_idx_d  = '0;
      cmp_vld_d = 1'b0;
    end else if (cmd_i.scan) begin
      rd_idx_d  = issue ? rd_idx_q + CW'(1) : rd_idx_q;
      cmp_vld_d = issue;
    end
  end

  assign count_d = insert ? count_q + CW'(1) : count_q;

  assign id_ext = hit_q ? 32'(slot_q) : 32'(count_q);

  always_comb begin
    out_d.link_id    = id_ext[pia_pkg::LINK_ID_W-1:0];
    out_d.found      = hit_q;
    out_d.table_full = !hit_q && (func_q == pia_pkg::FUNC_ASSIGN) && at_max;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      cmp_vld_q   <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      cmp_vld_q   <= cmp_vld_d;
      rd_idx_q    <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= key_d;
      func_q <= in_data_i.func;
    end
    if (cmd_i.scan) begin
      cmp_idx_q <= rd_idx_q;
      hit_q     <= hit;
      slot_q    <= cmp_idx_q;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_q;
  assign sts_o.hit      = hit;
  assign sts_o.miss     = miss;
  assign sts_o.out_busy = out_valid_q;

endmodule

`default_nettype wire

// ----- src/pair_id_assigner_core.sv -----
// Pair id assigner top level. Depends on pia_pkg, pia_ctrl, pia_dp, pia_ram
// and pair_id_assigner_core_macros.svh.
// Hands out ids for (from_node, to_node) pairs in order of first appearance;
// peek mode looks up without storing. One transaction is in flight at a time.
// A linear search of the pair memory, one entry per cycle through its
// registered read port, sets the time from acceptance to the result entering
// the output register: it grows with the slot on a hit and with pair_count on
// a miss, and any stall of the previous result in the output register adds
// to it. The output register lets a finished result wait while the next
// request is accepted. The pair memory needs no clearing after reset.
`default_nettype none
`include "pair_id_assigner_core_macros.svh"

module pair_id_assigner_core #(
  parameter int unsigned MAX_PAIRS = pia_pkg::MAX_PAIRS_DEF,
  parameter int unsigned NODE_BITS = pia_pkg::NODE_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire pia_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output pia_pkg::out_t     out_data_o
);

  pia_pkg::cmd_t cmd;
  pia_pkg::sts_t sts;

  pia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pia_dp #(
    .MAX_PAIRS (MAX_PAIRS),
    .NODE_BITS (NODE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  `PIA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
                   in_valid_i && !in_stall_o, in_stall_o,
                   "accepted transaction did not make the block busy")
  `PIA_ASSERT(a_emit_no_overwrite, clk_i, rst_ni,
              !cmd.emit || !out_valid_o || !out_stall_i,
              "result written over a stalled output")
  `PIA_ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, cmd.emit, out_valid_o,
                   "emitted result not presented")
  `PIA_ASSERT(a_full_not_found, clk_i, rst_ni,
              !out_valid_o || !(out_data_o.found && out_data_o.table_full),
              "found and table_full both set")

endmodule

`default_nettype wire

// ----- dv/pair_id_monitor.sv -----
// Watches both channels of pair_id_assigner_core, predicts each result and compares.
// Depends on pia_pkg; reports the mismatch count and the number of results still owed.
module pair_id_monitor
  import pia_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  output int unsigned errors_o,
  output int unsigned owed_o
);

  localparam int unsigned TABLE_DEPTH = MAX_PAIRS_DEF;

  logic [2*NODE_W-1:0] held_pairs [TABLE_DEPTH];
  int unsigned         held_cnt = 0;
  out_t                owed_ids [$];

  initial begin
    errors_o = 0;
    owed_o   = 0;
  end

  // Lookup in arrival order; assign inserts an absent pair while room is left.
  function automatic out_t lookup_or_insert(in_t req);
    logic [2*NODE_W-1:0] key;
    out_t                res;
    bit                  hit;
    int unsigned         slot;
    key  = {req.from_node, req.to_node};
    hit  = 1'b0;
    slot = 0;
    for (int unsigned i = 0; i < held_cnt; i++) begin
      if (!hit && held_pairs[i] == key) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    res.found      = hit;
    res.table_full = 1'b0;
    if (hit) begin
      res.link_id = LINK_ID_W'(slot);
    end else begin
      res.link_id = LINK_ID_W'(held_cnt);
      if (req.func == FUNC_ASSIGN) begin
        if (held_cnt < TABLE_DEPTH) begin
          held_pairs[held_cnt] = key;
          held_cnt++;
        end else begin
          res.table_full = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_ids.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result, expected none, actual id %0d found %0b full %0b",
                   $time, out_data_i.link_id, out_data_i.found, out_data_i.table_full);
        end else begin
          want = owed_ids.pop_front();
          if ($isunknown(out_data_i)) begin
            errors_o++;
            $display("%0t: unknown bits, expected %h, actual %h", $time, want, out_data_i);
          end else begin
            check_field("link_id", want.link_id, out_data_i.link_id);
            check_field("found", want.found, out_data_i.found);
            check_field("table_full", want.table_full, out_data_i.table_full);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        owed_ids.push_back(lookup_or_insert(in_data_i));
      owed_o = owed_ids.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Top of the pair_id_assigner_core bench: clock, reset, request stimulus, result stalls.
// Depends on pia_pkg, pair_id_assigner_core and pair_id_monitor.
module testbench;
  import pia_pkg::*;

  localparam int unsigned RAND_REQS   = 950;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_WAIT  = MAX_PAIRS_DEF + 8;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;
  int unsigned mismatches;
  int unsigned owed;
  int unsigned sent_cnt = 0;
  int unsigned cycle_cnt = 0;

  logic [2*NODE_W-1:0] seen_keys [$];

  pair_id_assigner_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  pair_id_monitor u_mon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .errors_o    (mismatches),
    .owed_o      (owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send_req(input logic func, input logic [NODE_W-1:0] src,
                          input logic [NODE_W-1:0] dst);
    in_t req;
    req.func      = func;
    req.from_node = src;
    req.to_node   = dst;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
    seen_keys.push_back({src, dst});
    if (seen_keys.size() > 600)
      void'(seen_keys.pop_front());
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Result side: random stalls, stall-free stretches and one long hold-off.
  initial begin
    int unsigned pick;
    int unsigned len;
    bit          held_off;
    held_off = 1'b0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      pick = $urandom_range(0, 99);
      if (!held_off && sent_cnt >= 300) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (600) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (pick < 10) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(100, 300)) @(posedge clk_i);
      end else begin
        len = (pick < 50) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (len > 0) begin
          out_stall_i <= 1'b1;
          repeat (len) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned         pick;
    int unsigned         gap;
    int unsigned         steady;
    logic                func;
    logic [2*NODE_W-1:0] key;
    steady = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty-table peek, hits, extreme and swapped node numbers.
    send_req(FUNC_PEEK,   16'h0000, 16'h0000);
    send_req(FUNC_ASSIGN, 16'h0000, 16'h0000);
    send_req(FUNC_ASSIGN, 16'h0000, 16'h0000);
    send_req(FUNC_PEEK,   16'h0000, 16'h0000);
    idle_gap(3);
    send_req(FUNC_ASSIGN, 16'hFFFF, 16'hFFFF);
    send_req(FUNC_ASSIGN, 16'h0000, 16'hFFFF);
    send_req(FUNC_ASSIGN, 16'hFFFF, 16'h0000);
    send_req(FUNC_PEEK,   16'hFFFF, 16'h0000);
    send_req(FUNC_PEEK,   16'h0001, 16'h0000);
    send_req(FUNC_ASSIGN, 16'h0000, 16'h0001);
    send_req(FUNC_ASSIGN, 16'h0001, 16'h0000);
    idle_gap(1);
    send_req(FUNC_ASSIGN, 16'h8000, 16'h8000);
    send_req(FUNC_ASSIGN, 16'h7FFF, 16'h7FFF);
    send_req(FUNC_ASSIGN, 16'hAAAA, 16'h5555);
    send_req(FUNC_ASSIGN, 16'h5555, 16'hAAAA);
    send_req(FUNC_PEEK,   16'h5555, 16'hAAAA);
    send_req(FUNC_ASSIGN, 16'hFFFF, 16'hFFFF);
    send_req(FUNC_PEEK,   16'h1234, 16'h4321);
    send_req(FUNC_ASSIGN, 16'h0001, 16'h0000);

    // New pairs arrive fast enough that the table fills well before the end.
    for (int unsigned n = 0; n < RAND_REQS; n++) begin
      pick = $urandom_range(0, 99);
      func = ($urandom_range(0, 99) < 20) ? FUNC_PEEK : FUNC_ASSIGN;
      if (pick < 45) begin
        key = $urandom;
        if ($urandom_range(0, 9) == 0)
          key[2*NODE_W-1:NODE_W] = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 9) == 0)
          key[NODE_W-1:0] = $urandom_range(0, 1) ? '1 : '0;
      end else begin
        key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
        if (pick >= 88)
          key[$urandom_range(0, 2*NODE_W-1)] ^= 1'b1;
      end
      send_req(func, key[2*NODE_W-1:NODE_W], key[NODE_W-1:0]);
      if (steady > 0) begin
        steady--;
        gap = 0;
      end else if ($urandom_range(0, 99) < 8) begin
        steady = $urandom_range(20, 60);
        gap = 0;
      end else begin
        pick = $urandom_range(0, 99);
        gap = (pick < 55) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
      idle_gap(gap);
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && owed == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
